FILE: src/ipv4rx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4rx_pkg
// Shared types and constants for the IPv4 receive header validator.
// ----------------------------------------------------------------------------
package ipv4rx_pkg;

    // Verdict codes
    localparam logic [2:0] ST_DELIVER    = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_VERSION    = 3'd2;
    localparam logic [2:0] ST_HDR_LEN    = 3'd3;
    localparam logic [2:0] ST_TOTAL_LEN  = 3'd4;
    localparam logic [2:0] ST_CHECKSUM   = 3'd5;
    localparam logic [2:0] ST_NO_HANDLER = 3'd6;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_PROTOCOLS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT     = 2'd1;

    // Protocol slots held in the slot_protocols register
    localparam int REG_SLOTS = 4;

    localparam logic [15:0] MIN_HDR      = 16'd20;
    localparam logic [15:0] SUM_GOOD     = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [3:0]  IP_VERSION_4 = 4'd4;

    // Per-frame values after the current byte has been folded in
    typedef struct packed {
        logic [15:0] frame_len;
        logic [3:0]  version;
        logic [5:0]  hdr_bytes;
        logic [15:0] datagram_len;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [15:0] sum;
    } frame_snap_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  handler_slot;
        logic [31:0] source_address;
        logic [7:0]  protocol;
        logic [5:0]  header_length;
        logic [15:0] payload_length;
    } verdict_t;

endpackage
`default_nettype wire

FILE: src/ipv4rx_hdr_track.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4rx_hdr_track
// Per-frame header tracking: byte count, captured fields and the running
// one's complement header sum. Cleared after the final byte of each frame.
// ----------------------------------------------------------------------------
module ipv4rx_hdr_track (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     step,
    input  wire logic [7:0]               data_byte,
    input  wire logic                     last,
    output ipv4rx_pkg::frame_snap_t       snap
);
    import ipv4rx_pkg::*;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] sum_acc_reg,    sum_acc_next;
    logic [7:0]  high_byte_reg,  high_byte_next;
    logic [3:0]  version_reg,    version_next;
    logic [5:0]  hdr_bytes_reg,  hdr_bytes_next;
    logic [15:0] total_reg,      total_next;
    logic [7:0]  proto_reg,      proto_next;
    logic [31:0] src_reg,        src_next;

    logic [16:0] sum_raw;
    logic [15:0] sum_folded;

    // End-around carry add of the current header word
    assign sum_raw    = {1'b0, sum_acc_reg} + {1'b0, high_byte_reg, data_byte};
    assign sum_folded = sum_raw[16] ? (sum_raw[15:0] + 16'd1) : sum_raw[15:0];

    always_comb
    begin
        version_next   = version_reg;
        hdr_bytes_next = hdr_bytes_reg;
        total_next     = total_reg;
        proto_next     = proto_reg;
        src_next       = src_reg;
        high_byte_next = high_byte_reg;
        sum_acc_next   = sum_acc_reg;

        if (byte_count_reg == 16'd0)
        begin
            version_next   = data_byte[7:4];
            hdr_bytes_next = {data_byte[3:0], 2'b00};
        end
        else if (byte_count_reg == 16'd2)
        begin
            total_next = {data_byte, total_reg[7:0]};
        end
        else if (byte_count_reg == 16'd3)
        begin
            total_next = {total_reg[15:8], data_byte};
        end
        else if (byte_count_reg == 16'd9)
        begin
            proto_next = data_byte;
        end
        else if (byte_count_reg >= 16'd12 && byte_count_reg <= 16'd15)
        begin
            src_next = {src_reg[23:0], data_byte};
        end

        // Sum only bytes that lie inside the header
        if (byte_count_reg < {10'd0, hdr_bytes_next})
        begin
            if (!byte_count_reg[0])
                high_byte_next = data_byte;
            else
                sum_acc_next = sum_folded;
        end

        byte_count_next = (byte_count_reg == COUNT_MAX) ? COUNT_MAX
                                                        : byte_count_reg + 16'd1;
    end

    assign snap.frame_len    = byte_count_next;
    assign snap.version      = version_next;
    assign snap.hdr_bytes    = hdr_bytes_next;
    assign snap.datagram_len = total_next;
    assign snap.proto        = proto_next;
    assign snap.src_addr     = src_next;
    assign snap.sum          = sum_acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            sum_acc_reg    <= '0;
            high_byte_reg  <= '0;
            version_reg    <= '0;
            hdr_bytes_reg  <= '0;
            total_reg      <= '0;
            proto_reg      <= '0;
            src_reg        <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                // Frame done: start the next one from scratch
                byte_count_reg <= '0;
                sum_acc_reg    <= '0;
                high_byte_reg  <= '0;
                version_reg    <= '0;
                hdr_bytes_reg  <= '0;
                total_reg      <= '0;
                proto_reg      <= '0;
                src_reg        <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                sum_acc_reg    <= sum_acc_next;
                high_byte_reg  <= high_byte_next;
                version_reg    <= version_next;
                hdr_bytes_reg  <= hdr_bytes_next;
                total_reg      <= total_next;
                proto_reg      <= proto_next;
                src_reg        <= src_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/ipv4rx_verdict.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4rx_verdict
// Header checks in priority order and protocol slot lookup for one frame.
// ----------------------------------------------------------------------------
module ipv4rx_verdict #(
    parameter int SLOTS = 4
) (
    input  wire ipv4rx_pkg::frame_snap_t snap,
    input  wire logic [31:0]             slot_protocols,
    input  wire logic [2:0]              slot_count,
    output ipv4rx_pkg::verdict_t         verdict
);
    import ipv4rx_pkg::*;

    localparam int LIM_CAP = (SLOTS < REG_SLOTS) ? SLOTS : REG_SLOTS;

    logic [2:0]  slot_lim;
    logic        hit;
    logic [1:0]  hit_slot;
    logic [15:0] hdr_wide;

    assign slot_lim = (slot_count > 3'(LIM_CAP)) ? 3'(LIM_CAP) : slot_count;
    assign hdr_wide = {10'd0, snap.hdr_bytes};

    // Walk down so the lowest matching slot is the one left standing
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = 2'd0;
        for (int i = REG_SLOTS - 1; i >= 0; i--)
        begin
            if ((3'(i) < slot_lim) && (slot_protocols[8*i +: 8] == snap.proto))
            begin
                hit      = 1'b1;
                hit_slot = 2'(i);
            end
        end
    end

    always_comb
    begin
        verdict.handler_slot   = 2'd0;
        verdict.payload_length = 16'd0;
        verdict.source_address = snap.src_addr;
        verdict.protocol       = snap.proto;
        verdict.header_length  = snap.hdr_bytes;

        if (snap.frame_len < MIN_HDR)
            verdict.status = ST_SHORT;
        else if (snap.version != IP_VERSION_4)
            verdict.status = ST_VERSION;
        else if (hdr_wide < MIN_HDR || hdr_wide > snap.frame_len)
            verdict.status = ST_HDR_LEN;
        else if (snap.datagram_len < hdr_wide || snap.datagram_len > snap.frame_len)
            verdict.status = ST_TOTAL_LEN;
        else if (snap.sum != SUM_GOOD)
            verdict.status = ST_CHECKSUM;
        else if (hit)
        begin
            verdict.status         = ST_DELIVER;
            verdict.handler_slot   = hit_slot;
            verdict.payload_length = snap.datagram_len - hdr_wide;
        end
        else
            verdict.status = ST_NO_HANDLER;
    end

endmodule
`default_nettype wire

FILE: src/ipv4_receive_header_validator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_receive_header_validator
// Checks the IPv4 header of a received packet byte by byte and gives one
// verdict with the handler slot on the final byte.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_ready  | data_byte, last
//  out      | out_valid / out_ready| status, handler_slot, source_address,
//           |                      | protocol, header_length, payload_length
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle. A byte is held in the input register, then
// updates the header state; a final byte loads the verdict into the output
// register in that same cycle. Only a final byte meeting a full, stalled
// output register holds the input register; other bytes keep flowing.
// Reset clears the valid flags, the header state and the two slot registers;
// cfg_ready is always high.
module ipv4_receive_header_validator #(
    parameter int SLOTS = 4
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          data_byte,
    input  wire logic                                last,

    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [2:0]                               status,
    output logic [1:0]                               handler_slot,
    output logic [31:0]                              source_address,
    output logic [7:0]                               protocol,
    output logic [5:0]                               header_length,
    output logic [15:0]                              payload_length,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ipv4rx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [31:0]                         cfg_data
);
    import ipv4rx_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    verdict_t    out_reg;
    logic [31:0] slot_protocols_reg;
    logic [2:0]  slot_count_reg;

    logic        out_free;
    logic        advance;
    frame_snap_t snap;
    verdict_t    verdict;

    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && (!in_last_reg || out_free);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    ipv4rx_hdr_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .snap      (snap)
    );

    ipv4rx_verdict #(
        .SLOTS (SLOTS)
    ) u_verdict (
        .snap           (snap),
        .slot_protocols (slot_protocols_reg),
        .slot_count     (slot_count_reg),
        .verdict        (verdict)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_reg <= verdict;
    end

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_protocols_reg <= '0;
            slot_count_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SLOT_PROTOCOLS: slot_protocols_reg <= cfg_data;
                CFG_SLOT_COUNT:     slot_count_reg     <= cfg_data[2:0];
                default:            ;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign handler_slot   = out_reg.handler_slot;
    assign source_address = out_reg.source_address;
    assign protocol       = out_reg.protocol;
    assign header_length  = out_reg.header_length;
    assign payload_length = out_reg.payload_length;

endmodule
`default_nettype wire

FILE: tb/ipv4_receive_header_validator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_receive_header_validator_test
// Streams IPv4 frames byte by byte into the validator, predicts each verdict
// from its own header tracker and compares every verdict field by field.
// Directed frames cover each verdict code and the slot register extremes.
// Random phases then mix well-formed headers with broken frames and noise,
// under random idling on both sides.
// ----------------------------------------------------------------------------
module ipv4_receive_header_validator_test;

    import ipv4rx_pkg::*;

    localparam int SLOTS        = 4;
    localparam int RANDOM_BYTES = 1050;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [3:0] IP_VERSION_6 = 4'd6;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } rx_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        last = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [1:0]  handler_slot;
    logic [31:0] source_address;
    logic [7:0]  protocol;
    logic [5:0]  header_length;
    logic [15:0] payload_length;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = 32'd0;

    // stimulus side
    rx_word_t    rx_bytes_pending[$];
    logic [7:0]  frame_bytes[$];
    logic [31:0] phase_protocols = 32'd0;
    bit          idling_on = 1'b1;
    int          send_gap = 0;
    int          hold_gap = 0;
    int          queued_bytes = 0;
    int          settings_used = 0;

    // header tracker, mirrors the block's per-frame state
    logic [15:0] seen_count = 16'd0;
    logic [15:0] sum_run = 16'd0;
    logic [7:0]  hi_run = 8'd0;
    logic [3:0]  ver_run = 4'd0;
    logic [5:0]  hlen_run = 6'd0;
    logic [15:0] tot_run = 16'd0;
    logic [7:0]  proto_run = 8'd0;
    logic [31:0] src_run = 32'd0;
    logic [31:0] slot_protos_cfg = 32'd0;
    logic [2:0]  slot_count_cfg = 3'd0;

    verdict_t    verdicts_due[$];
    int          verdict_tally[0:7];
    int          failures = 0;
    int          stall_cycles = 0;

    ipv4_receive_header_validator #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .handler_slot(handler_slot),
        .source_address(source_address),
        .protocol(protocol),
        .header_length(header_length),
        .payload_length(payload_length),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // one's complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? s[15:0] + 16'd1 : s[15:0];
    endfunction

    task automatic track_header_byte(input logic [7:0] b, input logic fin);
        logic [15:0] pos;
        verdict_t    v;
        int          lim;
        int          i;
        bit          hit;
        pos = seen_count;
        if (pos == 16'd0)
        begin
            ver_run  = b[7:4];
            hlen_run = {b[3:0], 2'b00};
        end
        else if (pos == 16'd2)
            tot_run[15:8] = b;
        else if (pos == 16'd3)
            tot_run[7:0] = b;
        else if (pos == 16'd9)
            proto_run = b;
        else if (pos >= 16'd12 && pos <= 16'd15)
            src_run = {src_run[23:0], b};
        // only bytes inside the header enter the sum
        if (pos < {10'd0, hlen_run})
        begin
            if (!pos[0])
                hi_run = b;
            else
                sum_run = ones_add(sum_run, {hi_run, b});
        end
        if (seen_count != COUNT_MAX)
            seen_count = seen_count + 16'd1;
        if (fin)
        begin
            v = '0;
            v.source_address = src_run;
            v.protocol       = proto_run;
            v.header_length  = hlen_run;
            if (seen_count < MIN_HDR)
                v.status = ST_SHORT;
            else if (ver_run != IP_VERSION_4)
                v.status = ST_VERSION;
            else if (hlen_run < MIN_HDR || hlen_run > seen_count)
                v.status = ST_HDR_LEN;
            else if (tot_run < hlen_run || tot_run > seen_count)
                v.status = ST_TOTAL_LEN;
            else if (sum_run != SUM_GOOD)
                v.status = ST_CHECKSUM;
            else
            begin
                lim = int'(slot_count_cfg);
                if (lim > SLOTS)
                    lim = SLOTS;
                if (lim > REG_SLOTS)
                    lim = REG_SLOTS;
                hit = 1'b0;
                // lowest enabled slot wins
                for (i = 0; i < lim; i++)
                begin
                    if (!hit && slot_protos_cfg[8*i +: 8] == proto_run)
                    begin
                        hit = 1'b1;
                        v.handler_slot = 2'(i);
                    end
                end
                if (hit)
                begin
                    v.status = ST_DELIVER;
                    v.payload_length = tot_run - {10'd0, hlen_run};
                end
                else
                    v.status = ST_NO_HANDLER;
            end
            verdicts_due.push_back(v);
            seen_count = 16'd0;
            sum_run    = 16'd0;
            hi_run     = 8'd0;
            ver_run    = 4'd0;
            hlen_run   = 6'd0;
            tot_run    = 16'd0;
            proto_run  = 8'd0;
            src_run    = 32'd0;
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            failures++;
        end
    endtask

    // fill frame_bytes with a header; with sum_ok the checksum makes the header sum fold to 0xFFFF
    task automatic build_header(input logic [3:0] ver, input logic [3:0] ihl,
                                input logic [15:0] total, input logic [7:0] proto,
                                input logic [31:0] src, input bit sum_ok);
        int          hlen;
        int          i;
        logic [15:0] sum;
        hlen = ihl * 4;
        frame_bytes.delete();
        frame_bytes.push_back({ver, ihl});
        for (i = 1; i < ((hlen > 20) ? hlen : 20); i++)
            frame_bytes.push_back(8'($urandom));
        frame_bytes[2]  = total[15:8];
        frame_bytes[3]  = total[7:0];
        frame_bytes[9]  = proto;
        frame_bytes[10] = 8'd0;
        frame_bytes[11] = 8'd0;
        for (i = 0; i < 4; i++)
            frame_bytes[12 + i] = src[31 - 8*i -: 8];
        sum = 16'd0;
        for (i = 0; i + 1 < hlen; i += 2)
            sum = ones_add(sum, {frame_bytes[i], frame_bytes[i + 1]});
        sum = ~sum;
        if (!sum_ok)
            sum = sum ^ 16'h0101;
        frame_bytes[10] = sum[15:8];
        frame_bytes[11] = sum[7:0];
    endtask

    task automatic append_random(input int n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic post_frame(input bit closed);
        rx_word_t w;
        int       i;
        for (i = 0; i < frame_bytes.size(); i++)
        begin
            w.data = frame_bytes[i];
            w.fin  = closed && (i == frame_bytes.size() - 1);
            rx_bytes_pending.push_back(w);
        end
        queued_bytes += frame_bytes.size();
    endtask

    task automatic queue_good(input logic [7:0] proto);
        build_header(IP_VERSION_4, 4'd5, 16'd20, proto, $urandom, 1'b1);
        post_frame(1'b1);
    endtask

    task automatic queue_random_frame();
        int         kind;
        int         ihl;
        int         pay;
        int         pad;
        int         k;
        logic [7:0] proto;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            // noise; a few bursts carry no final byte and run into the next frame
            frame_bytes.delete();
            append_random($urandom_range(1, 40));
            post_frame(kind >= 3);
        end
        else
        begin
            ihl = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 15) : 5;
            pay = $urandom_range(0, 12);
            pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if ($urandom_range(0, 9) < 7)
                proto = phase_protocols[8*$urandom_range(0, 3) +: 8];
            else
                proto = 8'($urandom);
            build_header(IP_VERSION_4, 4'(ihl), 16'(ihl * 4 + pay), proto, $urandom, 1'b1);
            append_random(pay + pad);
            if (kind < 35)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        k = $urandom_range(0, 19);
                        frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
                    end
                    1:
                    begin
                        k = $urandom_range(1, frame_bytes.size() - 1);
                        while (frame_bytes.size() > k)
                            void'(frame_bytes.pop_back());
                    end
                    default:
                        frame_bytes[$urandom_range(0, 19)] = 8'($urandom);
                endcase
            end
            post_frame(1'b1);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // wait until every word is sent and every verdict is in, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        while (rx_bytes_pending.size() != 0 || in_valid || verdicts_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] protos, input logic [2:0] count);
        settle();
        write_reg(CFG_SLOT_PROTOCOLS, protos);
        write_reg(CFG_SLOT_COUNT, {29'd0, count});
        phase_protocols = protos;
        settings_used++;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin : feed
        rx_word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (idling_on && rx_bytes_pending.size() != 0 && $urandom_range(0, 11) == 0)
            begin
                send_gap <= $urandom_range(0, 8);
                in_valid <= 1'b0;
            end
            else if (rx_bytes_pending.size() != 0)
            begin
                w = rx_bytes_pending.pop_front();
                in_valid  <= 1'b1;
                data_byte <= w.data;
                last      <= w.fin;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result sink with random stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_gap  <= 0;
        end
        else if (hold_gap != 0)
        begin
            hold_gap  <= hold_gap - 1;
            out_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            hold_gap  <= $urandom_range(0, 8);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // monitor: track config and bytes, check each verdict word
    always @(posedge clk)
    begin : score
        verdict_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SLOT_PROTOCOLS)
                    slot_protos_cfg = cfg_data;
                else if (cfg_index == CFG_SLOT_COUNT)
                    slot_count_cfg = cfg_data[2:0];
            end
            if (in_valid && in_ready)
                track_header_byte(data_byte, last);
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: verdict with none expected: status %0d, protocol %0h",
                             $time, status, protocol);
                    failures++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    check_field("status", want.status, status);
                    check_field("handler_slot", want.handler_slot, handler_slot);
                    check_field("source_address", want.source_address, source_address);
                    check_field("protocol", want.protocol, protocol);
                    check_field("header_length", want.header_length, header_length);
                    check_field("payload_length", want.payload_length, payload_length);
                    verdict_tally[want.status]++;
                end
            end
        end
    end

    // watchdog: any accepted word restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d verdicts outstanding",
                     $time, STALL_LIMIT, verdicts_due.size());
            $display("FAILED: results differ");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int          spent;
        int          phase_end;
        int          k;
        logic [31:0] protos;
        for (k = 0; k < 8; k++)
            verdict_tally[k] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // slot 3 repeats slot 0's protocol
        configure({PROTO_TCP, PROTO_ICMP, PROTO_UDP, PROTO_TCP}, 3'd4);
        frame_bytes.delete();
        frame_bytes.push_back(8'hFF);
        post_frame(1'b1);
        // header cut one byte short: the frame is shorter than the minimum header
        build_header(IP_VERSION_4, 4'd5, 16'd20, PROTO_TCP, 32'hC0A8_0001, 1'b1);
        void'(frame_bytes.pop_back());
        post_frame(1'b1);
        build_header(IP_VERSION_4, 4'd5, 16'd20, PROTO_TCP, 32'hFFFF_FFFF, 1'b1);
        post_frame(1'b1);
        build_header(IP_VERSION_4, 4'd5, 16'd24, PROTO_UDP, 32'h0000_0000, 1'b1);
        append_random(4);
        post_frame(1'b1);
        queue_good(PROTO_ICMP);
        queue_good(8'hFF);
        queue_good(8'h00);
        build_header(IP_VERSION_6, 4'd5, 16'd20, PROTO_TCP, $urandom, 1'b1);
        post_frame(1'b1);
        frame_bytes.delete();
        repeat (20) frame_bytes.push_back(8'h00);
        post_frame(1'b1);
        frame_bytes.delete();
        repeat (20) frame_bytes.push_back(8'hFF);
        post_frame(1'b1);
        build_header(IP_VERSION_4, 4'd4, 16'd20, PROTO_TCP, $urandom, 1'b1);
        post_frame(1'b1);
        build_header(IP_VERSION_4, 4'd0, 16'd20, PROTO_TCP, $urandom, 1'b1);
        post_frame(1'b1);
        // full 60-byte header, frame ends inside it
        build_header(IP_VERSION_4, 4'd15, 16'd60, PROTO_TCP, $urandom, 1'b1);
        while (frame_bytes.size() > 24)
            void'(frame_bytes.pop_back());
        post_frame(1'b1);
        build_header(IP_VERSION_4, 4'd15, 16'd63, PROTO_UDP, $urandom, 1'b1);
        append_random(3);
        post_frame(1'b1);
        build_header(IP_VERSION_4, 4'd5, 16'd19, PROTO_TCP, $urandom, 1'b1);
        post_frame(1'b1);
        build_header(IP_VERSION_4, 4'd5, 16'd40, PROTO_TCP, $urandom, 1'b1);
        append_random(5);
        post_frame(1'b1);
        build_header(IP_VERSION_4, 4'd5, 16'hFFFF, PROTO_TCP, $urandom, 1'b1);
        post_frame(1'b1);
        // trailing padding lies outside the summed header
        build_header(IP_VERSION_4, 4'd5, 16'd20, PROTO_TCP, $urandom, 1'b1);
        append_random(6);
        post_frame(1'b1);
        build_header(IP_VERSION_4, 4'd5, 16'd20, PROTO_TCP, $urandom, 1'b0);
        post_frame(1'b1);

        // slot count beyond the register: search stops at slot 3; spare indexes ignored
        configure(32'h3200_0000, 3'd7);
        write_reg(CFG_SPARE_2, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_3, 32'h0000_0000);
        queue_good(8'd50);
        queue_good(8'h00);
        configure(32'h3200_0000, 3'd3);
        queue_good(8'd50);
        configure(32'hFFFF_FFFF, 3'd1);
        queue_good(8'hFF);
        queue_good(8'd50);
        configure(32'h0000_0000, 3'd0);
        queue_good(PROTO_TCP);
        queue_good(8'h00);

        spent = queued_bytes;
        while (queued_bytes - spent < RANDOM_BYTES)
        begin
            for (k = 0; k < 4; k++)
            begin
                case ($urandom_range(0, 3))
                    0:       protos[8*k +: 8] = PROTO_TCP;
                    1:       protos[8*k +: 8] = PROTO_UDP;
                    2:       protos[8*k +: 8] = PROTO_ICMP;
                    default: protos[8*k +: 8] = 8'($urandom);
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                protos = 32'h0000_0000;
            else if ($urandom_range(0, 9) == 0)
                protos = 32'hFFFF_FFFF;
            configure(protos, ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'd4);
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
            // no idling at all near the end
            idling_on = (RANDOM_BYTES - (queued_bytes - spent) > 250)
                        && ($urandom_range(0, 4) != 0);
            phase_end = queued_bytes + 150;
            while (queued_bytes < phase_end)
                queue_random_frame();
        end

        settle();
        $display("Sent %0d bytes under %0d slot settings.", queued_bytes, settings_used);
        $display("Verdicts: ok %0d, short %0d, ver %0d, hdr %0d, total %0d, sum %0d, none %0d",
                 verdict_tally[ST_DELIVER], verdict_tally[ST_SHORT], verdict_tally[ST_VERSION],
                 verdict_tally[ST_HDR_LEN], verdict_tally[ST_TOTAL_LEN],
                 verdict_tally[ST_CHECKSUM], verdict_tally[ST_NO_HANDLER]);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
